/* rtl/morse_timing_decoder_core_macros.svh */
// ----------------------------------------------------------------------------
// morse timing decoder assertion macros
// concurrent property wrappers shared by the checker
// ----------------------------------------------------------------------------
`ifndef MORSE_TIMING_DECODER_CORE_MACROS_SVH
`define MORSE_TIMING_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mtd_pkg.sv */
// ----------------------------------------------------------------------------
// mtd_pkg
// shared types, codes and letter tables of the morse timing decoder
// ----------------------------------------------------------------------------
`default_nettype none

package mtd_pkg;

    localparam int MAX_SYMBOL_LEN_DEF = 4;
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int BURST_MAX          = 4;
    localparam int NUM_LETTERS        = 26;

    localparam int RUN_W = 4;
    localparam logic [RUN_W-1:0] RUN_SAT = 4'hF;

    // result kinds
    localparam logic [1:0] KIND_LETTER  = 2'd0;
    localparam logic [1:0] KIND_SPACE   = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;
    localparam logic [1:0] KIND_UNRECOG = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DOT_UNITS        = 2'd0;
    localparam logic [1:0] CFG_DASH_UNITS       = 2'd1;
    localparam logic [1:0] CFG_LETTER_GAP_UNITS = 2'd2;
    localparam logic [1:0] CFG_WORD_GAP_UNITS   = 2'd3;

    localparam logic [3:0] DOT_UNITS_RST        = 4'd1;
    localparam logic [3:0] DASH_UNITS_RST       = 4'd3;
    localparam logic [3:0] LETTER_GAP_UNITS_RST = 4'd3;
    localparam logic [3:0] WORD_GAP_UNITS_RST   = 4'd7;

    // element patterns, dot 0 dash 1, first element in bit 0
    localparam logic [3:0] LETTER_BITS [NUM_LETTERS] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };
    localparam logic [2:0] LETTER_LEN [NUM_LETTERS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    typedef struct packed {
        logic mark;
        logic end_of_line;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] letter;
        logic [3:0] symbol_pattern;
        logic [2:0] symbol_count;
        logic       last_result;
    } t_out;

    // all results caused by one input unit
    typedef struct packed {
        logic [2:0]             count;
        t_out [BURST_MAX-1:0]   res;
    } t_burst;

endpackage

`default_nettype wire

/* rtl/mtd_symbol_lookup.sv */
// ----------------------------------------------------------------------------
// mtd_symbol_lookup
// maps a collected symbol to a letter result or an unrecognised result
// ----------------------------------------------------------------------------
`default_nettype none

module mtd_symbol_lookup #(
    parameter int MAX_SYMBOL_LEN = mtd_pkg::MAX_SYMBOL_LEN_DEF
) (
    input  logic [MAX_SYMBOL_LEN-1:0]               i_bits,
    input  logic [$clog2(MAX_SYMBOL_LEN+2)-1:0]     i_len,
    output mtd_pkg::t_out                           o_res
);
    import mtd_pkg::*;

    localparam int LEN_W = $clog2(MAX_SYMBOL_LEN + 2);

    logic       found;
    logic [4:0] idx;

    // independent compares, lowest index wins
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
            if (i_len == LEN_W'(LETTER_LEN[i]) &&
                i_bits == MAX_SYMBOL_LEN'(LETTER_BITS[i])) begin
                found = 1'b1;
                idx   = 5'(i);
            end
        end
    end

    always_comb begin
        o_res.kind           = found ? KIND_LETTER : KIND_UNRECOG;
        o_res.letter         = found ? idx : 5'd0;
        o_res.symbol_pattern = i_bits[3:0];
        o_res.symbol_count   = 3'(i_len);
        o_res.last_result    = 1'b0;
    end

endmodule

`default_nettype wire

/* rtl/mtd_step.sv */
// ----------------------------------------------------------------------------
// mtd_step
// run and symbol state, and the result burst of one signal unit
// ----------------------------------------------------------------------------
`default_nettype none

module mtd_step #(
    parameter int MAX_SYMBOL_LEN = mtd_pkg::MAX_SYMBOL_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  mtd_pkg::t_in    i_in,
    input  logic [3:0]      i_dot_units,
    input  logic [3:0]      i_dash_units,
    input  logic [3:0]      i_letter_gap_units,
    input  logic [3:0]      i_word_gap_units,
    output mtd_pkg::t_burst o_burst
);
    import mtd_pkg::*;

    localparam int LEN_W = $clog2(MAX_SYMBOL_LEN + 2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SYMBOL_LEN);
    localparam logic [LEN_W-1:0] LEN_OVF = LEN_W'(MAX_SYMBOL_LEN + 1);

    logic [RUN_W-1:0]          r_mark_run, n_mark_run;
    logic [RUN_W-1:0]          r_gap_run,  n_gap_run;
    logic [MAX_SYMBOL_LEN-1:0] r_sym_bits, n_sym_bits;
    logic [LEN_W-1:0]          r_sym_len,  n_sym_len;

    logic [RUN_W-1:0]          mark_inc;
    logic                      word_hit, letter_hit;
    logic [MAX_SYMBOL_LEN-1:0] mid_bits, closed_bits;
    logic [LEN_W-1:0]          mid_len,  closed_len;
    logic [RUN_W-1:0]          close_run;
    logic                      is_dot, is_dash, add_elem;
    t_out                      res_old, res_closed;

    assign mark_inc = i_in.mark ? ((r_mark_run == RUN_SAT) ? r_mark_run
                                                           : r_mark_run + 4'd1)
                                : '0;

    assign word_hit   = i_in.mark && r_gap_run != '0 && r_gap_run == i_word_gap_units;
    assign letter_hit = i_in.mark && !word_hit && r_gap_run != '0 &&
                        r_gap_run == i_letter_gap_units;

    // symbol after a gap-ended emission
    assign mid_bits = (word_hit || letter_hit) ? '0 : r_sym_bits;
    assign mid_len  = (word_hit || letter_hit) ? '0 : r_sym_len;

    // a gap unit or the end of line closes the mark run
    assign close_run = i_in.mark ? mark_inc : r_mark_run;
    assign is_dot    = close_run != '0 && close_run == i_dot_units;
    assign is_dash   = !is_dot && close_run != '0 && close_run == i_dash_units;
    assign add_elem  = (!i_in.mark || i_in.end_of_line) && (is_dot || is_dash);

    always_comb begin
        closed_bits = mid_bits;
        closed_len  = mid_len;
        if (add_elem) begin
            if (mid_len < LEN_MAX) begin
                closed_bits = mid_bits |
                    ({{(MAX_SYMBOL_LEN-1){1'b0}}, is_dash} << mid_len);
                closed_len  = mid_len + 1'b1;
            end else begin
                closed_len  = LEN_OVF;
            end
        end
    end

    mtd_symbol_lookup #(
        .MAX_SYMBOL_LEN (MAX_SYMBOL_LEN)
    ) u_lookup_old (
        .i_bits (r_sym_bits),
        .i_len  (r_sym_len),
        .o_res  (res_old)
    );

    mtd_symbol_lookup #(
        .MAX_SYMBOL_LEN (MAX_SYMBOL_LEN)
    ) u_lookup_closed (
        .i_bits (closed_bits),
        .i_len  (closed_len),
        .o_res  (res_closed)
    );

    // burst in emission order
    always_comb begin
        t_burst b;
        t_out   blank;
        blank = '0;
        b     = '0;
        if (word_hit || letter_hit) begin
            b.res[b.count[1:0]] = res_old;
            b.count = b.count + 3'd1;
        end
        if (word_hit) begin
            b.res[b.count[1:0]]      = blank;
            b.res[b.count[1:0]].kind = KIND_SPACE;
            b.count = b.count + 3'd1;
        end
        if (i_in.end_of_line) begin
            b.res[b.count[1:0]] = res_closed;
            b.count = b.count + 3'd1;
            b.res[b.count[1:0]]      = blank;
            b.res[b.count[1:0]].kind = KIND_NEWLINE;
            b.count = b.count + 3'd1;
        end
        if (b.count != 3'd0) begin
            b.res[2'(b.count - 3'd1)].last_result = 1'b1;
        end
        o_burst = b;
    end

    always_comb begin
        if (i_in.end_of_line) begin
            n_mark_run = '0;
            n_gap_run  = '0;
            n_sym_bits = '0;
            n_sym_len  = '0;
        end else begin
            n_mark_run = mark_inc;
            n_gap_run  = i_in.mark ? '0 : ((r_gap_run == RUN_SAT) ? r_gap_run
                                                                  : r_gap_run + 4'd1);
            n_sym_bits = closed_bits;
            n_sym_len  = closed_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_run <= '0;
            r_gap_run  <= '0;
            r_sym_bits <= '0;
            r_sym_len  <= '0;
        end else if (i_accept) begin
            r_mark_run <= n_mark_run;
            r_gap_run  <= n_gap_run;
            r_sym_bits <= n_sym_bits;
            r_sym_len  <= n_sym_len;
        end
    end

endmodule

`default_nettype wire

/* rtl/mtd_burst_queue.sv */
// ----------------------------------------------------------------------------
// mtd_burst_queue
// holds result bursts and hands out their results one transfer at a time
// ----------------------------------------------------------------------------
`default_nettype none

module mtd_burst_queue #(
    parameter int QUEUE_DEPTH = mtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtd_pkg::t_burst i_burst,
    output logic            o_full,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mtd_pkg::t_out   o_out
);
    import mtd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_burst           r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_sel;
    t_burst           head;
    logic             pop, pop_last;

    assign head        = r_slot[r_rd_ptr];
    assign o_out       = head.res[r_sel];
    assign o_out_valid = r_count != '0;
    assign o_full      = r_count == CNT_FULL;
    assign pop         = o_out_valid && i_out_ready;
    assign pop_last    = pop && o_out.last_result;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sel    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_last) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                r_sel    <= '0;
            end else if (pop) begin
                r_sel    <= r_sel + 2'd1;
            end
            if (i_push && !pop_last) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop_last) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/morse_timing_decoder_core.sv */
// ----------------------------------------------------------------------------
// morse_timing_decoder_core
// decodes a sampled morse signal, one time unit per transfer, into letters,
// spaces and newlines
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  in        input      i_in_valid / o_in_ready        i_in  (mark, end_of_line)
//  out       output     o_out_valid / i_out_ready      o_out (kind .. last_result)
//  cfg       input      i_cfg_we (no back-pressure)    i_cfg_index, i_cfg_data
//
//  one signal unit is taken per clock while the queue has room; its zero to four
//  results are queued the cycle after the transfer and leave one per ready cycle
//  o_in_ready falls only when QUEUE_DEPTH bursts of results are waiting
//  synchronous active-low reset restores the default timings and clears
//  the run counters, the open symbol and the result queue
//  stalls on the out side hold the shown result; the in side keeps going
//  until the queue is full
//
`default_nettype none

module morse_timing_decoder_core #(
    parameter int MAX_SYMBOL_LEN = mtd_pkg::MAX_SYMBOL_LEN_DEF,
    parameter int QUEUE_DEPTH    = mtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // signal units in
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mtd_pkg::t_in  i_in,
    // decoded results out
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mtd_pkg::t_out o_out,
    // timing registers
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [3:0]    i_cfg_data
);
    import mtd_pkg::*;

    // timing registers, the user writes only while the decoder is quiet; unchecked
    logic [3:0] r_dot_units;
    logic [3:0] r_dash_units;
    logic [3:0] r_letter_gap_units;
    logic [3:0] r_word_gap_units;

    logic   queue_full;
    logic   in_xfer;
    t_burst burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_units        <= DOT_UNITS_RST;
            r_dash_units       <= DASH_UNITS_RST;
            r_letter_gap_units <= LETTER_GAP_UNITS_RST;
            r_word_gap_units   <= WORD_GAP_UNITS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DOT_UNITS:        r_dot_units        <= i_cfg_data;
                CFG_DASH_UNITS:       r_dash_units       <= i_cfg_data;
                CFG_LETTER_GAP_UNITS: r_letter_gap_units <= i_cfg_data;
                CFG_WORD_GAP_UNITS:   r_word_gap_units   <= i_cfg_data;
                default:              r_dot_units        <= r_dot_units;
            endcase
        end
    end

    // a unit is taken whenever a slot for its burst is free
    assign o_in_ready = !queue_full;
    assign in_xfer    = i_in_valid && o_in_ready;

    // run counting, element collection and the result burst of this unit
    mtd_step #(
        .MAX_SYMBOL_LEN (MAX_SYMBOL_LEN)
    ) u_step (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_xfer),
        .i_in               (i_in),
        .i_dot_units        (r_dot_units),
        .i_dash_units       (r_dash_units),
        .i_letter_gap_units (r_letter_gap_units),
        .i_word_gap_units   (r_word_gap_units),
        .o_burst            (burst)
    );

    // bursts with no result are not queued
    mtd_burst_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_xfer && burst.count != 3'd0),
        .i_burst     (burst),
        .o_full      (queue_full),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* rtl/mtd_checker.sv */
// ----------------------------------------------------------------------------
// mtd_checker
// port-level checks of the morse timing decoder
// ----------------------------------------------------------------------------
`default_nettype none

`include "morse_timing_decoder_core_macros.svh"

module mtd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input mtd_pkg::t_out o_out
);
    import mtd_pkg::*;

    `MTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result changed")

    `MTD_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out.last_result, o_out_valid, "burst broken before its last result")

    `MTD_ASSERT_IMPLY(a_letter_fields, i_clk, i_rst_n, o_out_valid && o_out.kind == KIND_LETTER, o_out.letter <= 5'd25 && o_out.symbol_count != 3'd0 && o_out.symbol_count <= 3'd4, "letter result out of range")

    `MTD_ASSERT_IMPLY(a_newline_last, i_clk, i_rst_n, o_out_valid && o_out.kind == KIND_NEWLINE, o_out.last_result && o_out.letter == 5'd0 && o_out.symbol_pattern == 4'd0 && o_out.symbol_count == 3'd0, "newline not a clean last result")

endmodule

bind morse_timing_decoder_core mtd_checker u_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the morse timing decoder: a short table of signal
// units, then words of random morse in well-formed timing mixed with noise,
// over several timing settings, with idle and stall mixes on both channels
// and one long output hold-off that fills the result queue
// ----------------------------------------------------------------------------

module tb_top;

    import mtd_pkg::*;

    localparam int SYM_MAX       = 4;        // elements kept before overflow
    localparam logic [3:0] RUN_MAX = 4'd15;  // run counters stop here
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int NUM_DIR       = 26;

    // the four kinds of signal unit
    localparam t_in U_GAP      = '{mark: 1'b0, end_of_line: 1'b0};
    localparam t_in U_MARK     = '{mark: 1'b1, end_of_line: 1'b0};
    localparam t_in U_GAP_EOL  = '{mark: 1'b0, end_of_line: 1'b1};
    localparam t_in U_MARK_EOL = '{mark: 1'b1, end_of_line: 1'b1};

    localparam t_out NO_CHAR = '0;
    localparam t_out NL_LAST = '{KIND_NEWLINE, 5'd0, 4'd0, 3'd0, 1'b1};

    // one row of the directed table: the unit and, where obvious, its characters
    typedef struct packed {
        t_in        sig;
        logic [1:0] n_typed;
        t_out       exp_a;
        t_out       exp_b;
    } t_dir_row;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    t_in   in_sig;
    logic  out_valid;
    logic  out_ready;
    t_out  out_char;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    // timing registers as the decoder should hold them
    logic [3:0] dot_len, dash_len, letter_gap_len, word_gap_len;
    // decoder state as it should be
    logic [3:0] key_run, space_run;
    logic [3:0] elem_bits;
    logic [2:0] elem_cnt;

    t_out unit_chars[$];     // characters caused by the unit being decoded
    t_out decoded_chars[$];  // characters still to come out, oldest first

    // typed-in characters for the unit on offer, zero means use the decoder model
    int   typed_n;
    t_out typed_a, typed_b;

    t_dir_row dir_tab [NUM_DIR];

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_req      = 1'b0;
    int   units_sent    = 0;
    int   phase_end     = 0;     // runs stop sending once this many units went in
    int   n_chars       = 0;
    int   n_kind [4]    = '{0, 0, 0, 0};
    int   full_stalls   = 0;
    int   errors        = 0;
    int   cycles        = 0;

    morse_timing_decoder_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_sig),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_char),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 12 ns period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------

    // letter index of a complete symbol, -1 when not a letter
    function automatic int letter_index(logic [2:0] len, logic [3:0] bits);
        case ({len, bits})
            {3'd2, 4'd2}:  return 0;   // a .-
            {3'd4, 4'd1}:  return 1;   // b -...
            {3'd4, 4'd5}:  return 2;   // c -.-.
            {3'd3, 4'd1}:  return 3;   // d -..
            {3'd1, 4'd0}:  return 4;   // e .
            {3'd4, 4'd4}:  return 5;   // f ..-.
            {3'd3, 4'd3}:  return 6;   // g --.
            {3'd4, 4'd0}:  return 7;   // h ....
            {3'd2, 4'd0}:  return 8;   // i ..
            {3'd4, 4'd14}: return 9;   // j .---
            {3'd3, 4'd5}:  return 10;  // k -.-
            {3'd4, 4'd2}:  return 11;  // l .-..
            {3'd2, 4'd3}:  return 12;  // m --
            {3'd2, 4'd1}:  return 13;  // n -.
            {3'd3, 4'd7}:  return 14;  // o ---
            {3'd4, 4'd6}:  return 15;  // p .--.
            {3'd4, 4'd11}: return 16;  // q --.-
            {3'd3, 4'd2}:  return 17;  // r .-.
            {3'd3, 4'd0}:  return 18;  // s ...
            {3'd1, 4'd1}:  return 19;  // t -
            {3'd3, 4'd4}:  return 20;  // u ..-
            {3'd4, 4'd8}:  return 21;  // v ...-
            {3'd3, 4'd6}:  return 22;  // w .--
            {3'd4, 4'd9}:  return 23;  // x -..-
            {3'd4, 4'd13}: return 24;  // y -.--
            {3'd4, 4'd3}:  return 25;  // z --..
            default:       return -1;
        endcase
    endfunction

    function void push_char(logic [1:0] kind, logic [4:0] letter, logic [3:0] pat,
                            logic [2:0] cnt);
        t_out c;
        c = '{kind, letter, pat, cnt, 1'b0};
        unit_chars.push_back(c);
    endfunction

    function void add_element(logic dash);
        if (elem_cnt < SYM_MAX) begin
            if (dash)
                elem_bits[elem_cnt[1:0]] = 1'b1;
            elem_cnt = elem_cnt + 3'd1;
        end else begin
            // too long: stays unrecognised
            elem_cnt = 3'(SYM_MAX + 1);
        end
    endfunction

    // end of a key-down run: dot wins over dash when both lengths match
    function void close_key_run();
        if (key_run != 0 && key_run == dot_len)
            add_element(1'b0);
        else if (key_run != 0 && key_run == dash_len)
            add_element(1'b1);
        key_run = '0;
    endfunction

    function void flush_symbol();
        int idx;
        idx = letter_index(elem_cnt, elem_bits);
        if (idx >= 0)
            push_char(KIND_LETTER, 5'(idx), elem_bits, elem_cnt);
        else
            push_char(KIND_UNRECOG, 5'd0, elem_bits, elem_cnt);
        elem_bits = '0;
        elem_cnt  = '0;
    endfunction

    // one signal unit into unit_chars, last flag on the final character
    function void decode_unit(t_in s);
        t_out c;
        unit_chars.delete();
        if (s.mark) begin
            // a gap ends here: word gap beats letter gap when equal
            if (space_run != 0 && space_run == word_gap_len) begin
                flush_symbol();
                push_char(KIND_SPACE, 5'd0, 4'd0, 3'd0);
            end else if (space_run != 0 && space_run == letter_gap_len) begin
                flush_symbol();
            end
            space_run = '0;
            if (key_run != RUN_MAX)
                key_run = key_run + 4'd1;
        end else begin
            close_key_run();
            if (space_run != RUN_MAX)
                space_run = space_run + 4'd1;
        end
        if (s.end_of_line) begin
            close_key_run();
            flush_symbol();
            push_char(KIND_NEWLINE, 5'd0, 4'd0, 3'd0);
            space_run = '0;
        end
        if (unit_chars.size() != 0) begin
            c = unit_chars.pop_back();
            c.last_result = 1'b1;
            unit_chars.push_back(c);
        end
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor: unit transfers feed the model, character transfers are checked
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_out want;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycles, decoded_chars.size());
            $display("Some tests failed");
            $finish;
        end
        if (rst_n) begin
            if (in_valid && !in_ready)
                full_stalls++;
            if (in_valid && in_ready) begin
                decode_unit(in_sig);
                if (typed_n == 0) begin
                    foreach (unit_chars[k])
                        decoded_chars.push_back(unit_chars[k]);
                end else begin
                    decoded_chars.push_back(typed_a);
                    if (typed_n == 2)
                        decoded_chars.push_back(typed_b);
                end
            end
            if (out_valid && out_ready) begin
                if (decoded_chars.size() == 0) begin
                    $error("character with none expected: kind %0d letter %0d",
                           out_char.kind, out_char.letter);
                    errors++;
                end else begin
                    want = decoded_chars.pop_front();
                    n_chars++;
                    n_kind[want.kind]++;
                    cmp_field("kind", 8'(want.kind), 8'(out_char.kind));
                    cmp_field("letter", 8'(want.letter), 8'(out_char.letter));
                    cmp_field("symbol_pattern", 8'(want.symbol_pattern),
                              8'(out_char.symbol_pattern));
                    cmp_field("symbol_count", 8'(want.symbol_count),
                              8'(out_char.symbol_count));
                    cmp_field("last_result", 8'(want.last_result),
                              8'(out_char.last_result));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off when asked for one
    // ------------------------------------------------------------------------
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offer one unit from a falling edge, return at the falling edge after the transfer
    task automatic send_unit(t_in s, int n_typed, t_out exp_a, t_out exp_b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_sig   <= s;
        typed_n  = n_typed;
        typed_a  = exp_a;
        typed_b  = exp_b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        units_sent++;
        @(negedge clk);
    endtask

    // a run of one unit kind, cut short once the phase has its units
    task automatic send_run(logic key, int len, logic eol_last);
        t_in s;
        for (int k = 0; k < len && units_sent < phase_end; k++) begin
            s.mark        = key;
            s.end_of_line = eol_last && (k == len - 1);
            send_unit(s, 0, NO_CHAR, NO_CHAR);
        end
    endtask

    // the run length a register asks for, or now and then a stray one
    function automatic int run_len(logic [3:0] want);
        if (want == 0 || $urandom_range(15) == 0)
            return $urandom_range(1, 18);
        return want;
    endfunction

    // a word of random letters in the current timing, ended by a word gap or a line end
    task automatic send_word();
        int n_let;
        int n_el;
        n_let = $urandom_range(1, 4);
        for (int l = 0; l < n_let; l++) begin
            n_el = ($urandom_range(7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            for (int e = 0; e < n_el; e++) begin
                send_run(1'b1, run_len($urandom_range(1) ? dash_len : dot_len), 1'b0);
                if (e != n_el - 1)
                    send_run(1'b0, ($urandom_range(15) == 0) ? $urandom_range(1, 18) : 1,
                             1'b0);
            end
            if (l != n_let - 1)
                send_run(1'b0, run_len(letter_gap_len), 1'b0);
        end
        case ($urandom_range(3))
            0:       send_run(1'b0, $urandom_range(1, 4), 1'b1);  // line ends on a gap
            1:       send_run(1'b1, 1, 1'b1);                     // line ends on a mark
            default: send_run(1'b0, run_len(word_gap_len), 1'b0);
        endcase
    endtask

    // scattered units, sometimes a run long enough to saturate
    task automatic send_noise();
        t_in s;
        int  n;
        n = $urandom_range(3, 12);
        repeat (n) begin
            s.mark        = 1'($urandom_range(1));
            s.end_of_line = ($urandom_range(7) == 0);
            send_unit(s, 0, NO_CHAR, NO_CHAR);
        end
        if ($urandom_range(3) == 0)
            send_run(1'($urandom_range(1)), $urandom_range(14, 20), 1'b0);
    endtask

    // wait for every character, then let the decoder go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (decoded_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // all four timing registers, one write per cycle
    task automatic set_timings(logic [3:0] d, logic [3:0] da, logic [3:0] lg, logic [3:0] wg);
        logic [3:0] vals [4];
        logic [1:0] idx  [4];
        vals = '{d, da, lg, wg};
        idx  = '{CFG_DOT_UNITS, CFG_DASH_UNITS, CFG_LETTER_GAP_UNITS, CFG_WORD_GAP_UNITS};
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            case (idx[k])
                CFG_DOT_UNITS:        dot_len        = vals[k];
                CFG_DASH_UNITS:       dash_len       = vals[k];
                CFG_LETTER_GAP_UNITS: letter_gap_len = vals[k];
                CFG_WORD_GAP_UNITS:   word_gap_len   = vals[k];
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [3:0] d, logic [3:0] da, logic [3:0] lg, logic [3:0] wg,
                             int idle_pct, int stall, int n_units);
        int target;
        settle();
        set_timings(d, da, lg, wg);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        target        = units_sent + n_units;
        phase_end     = target;
        while (units_sent < target) begin
            if ($urandom_range(9) == 0)
                send_noise();
            else
                send_word();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_sig    = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_DOT_UNITS;
        cfg_data  = '0;
        typed_n   = 0;
        typed_a   = NO_CHAR;
        typed_b   = NO_CHAR;

        // reset values of the timing registers and the state
        dot_len        = DOT_UNITS_RST;
        dash_len       = DASH_UNITS_RST;
        letter_gap_len = LETTER_GAP_UNITS_RST;
        word_gap_len   = WORD_GAP_UNITS_RST;
        key_run        = '0;
        space_run      = '0;
        elem_bits      = '0;
        elem_cnt       = '0;

        dir_tab = '{
            // empty symbol at a bare line end
            '{U_GAP_EOL, 2'd2, '{KIND_UNRECOG, 5'd0, 4'd0, 3'd0, 1'b0}, NL_LAST},
            // single mark closed by the line end: e
            '{U_MARK_EOL, 2'd2, '{KIND_LETTER, 5'd4, 4'd0, 3'd1, 1'b0}, NL_LAST},
            // five dots: overflow
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR}, '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR}, '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR}, '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR}, '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR},
            '{U_GAP_EOL, 2'd2, '{KIND_UNRECOG, 5'd0, 4'd0, 3'd5, 1'b0}, NL_LAST},
            // dot, dash, word gap: a then space, then e at the line end
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR}, '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR}, '{U_MARK, 2'd0, NO_CHAR, NO_CHAR},
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR},
            '{U_GAP, 2'd0, NO_CHAR, NO_CHAR}, '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_GAP, 2'd0, NO_CHAR, NO_CHAR}, '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_GAP, 2'd0, NO_CHAR, NO_CHAR}, '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_GAP, 2'd0, NO_CHAR, NO_CHAR},
            '{U_MARK, 2'd0, NO_CHAR, NO_CHAR},
            '{U_GAP_EOL, 2'd0, NO_CHAR, NO_CHAR}
        };

        // reset held, then released on a falling edge
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed units at the reset timing, no idling
        for (int r = 0; r < NUM_DIR; r++)
            send_unit(dir_tab[r].sig, dir_tab[r].n_typed, dir_tab[r].exp_a, dir_tab[r].exp_b);

        // random words over several timings and idle mixes
        run_phase(4'd1,  4'd3,  4'd3,  4'd7,  0,  0,  60);
        run_phase(4'd2,  4'd5,  4'd4,  4'd9,  54, 0,  60);
        run_phase(4'd1,  4'd15, 4'd15, 4'd1,  0,  54, 60);
        run_phase(4'd0,  4'd2,  4'd0,  4'd5,  35, 35, 60);  // zero registers match nothing
        run_phase(4'd3,  4'd3,  4'd4,  4'd4,  35, 35, 60);  // equal dot/dash and gaps
        run_phase(4'd15, 4'd15, 4'd15, 4'd15, 0,  0,  60);

        // long receiver hold-off while line ends keep arriving, so the queue fills
        settle();
        set_timings(DOT_UNITS_RST, DASH_UNITS_RST, LETTER_GAP_UNITS_RST, WORD_GAP_UNITS_RST);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        phase_end = units_sent + 40;
        repeat (40) send_run(1'b0, 1, 1'b1);
        run_phase(4'd1, 4'd3, 4'd3, 4'd7, 20, 20, 30);

        settle();
        $display("%0d units, %0d characters: %0d letters %0d spaces %0d newlines %0d unrecognised",
                 units_sent, n_chars, n_kind[KIND_LETTER], n_kind[KIND_SPACE],
                 n_kind[KIND_NEWLINE], n_kind[KIND_UNRECOG]);
        $display("seven timing settings with idle and stall mixes, input held off %0d cycles",
                 full_stalls);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mtd_pkg.sv
rtl/mtd_symbol_lookup.sv
rtl/mtd_step.sv
rtl/mtd_burst_queue.sv
rtl/morse_timing_decoder_core.sv
rtl/mtd_checker.sv
sim/tb_top.sv
